// ===== rtl/tfn_pkg.sv =====
package tfn_pkg;

    localparam int COORD_W = 16;
    localparam int EDGE_W  = 17;
    localparam int PROD_W  = 34;
    localparam int CROSS_W = 35;
    localparam int MAG_W   = 34;
    localparam int RED_W   = 31;
    localparam int SUM_W   = 64;
    localparam int ROOT_W  = 32;
    localparam int FRAC_OUT = 14;
    localparam int QUOT_W  = FRAC_OUT + 1;
    localparam int OUT_W   = 16;
    localparam int SQRT_STEPS = 32;

    localparam logic [OUT_W-1:0] ONE_OUT = OUT_W'(1) << FRAC_OUT;

    typedef struct packed {
        logic [2:0] neg;
        logic       degen;
    } t_meta;

endpackage

// ===== rtl/triangle_face_normal_core.sv =====
// Triangle face normal, fully pipelined.
// Slave channel: one triangle per transfer. i_s_tdata carries, from the lowest
// bit up, vertex_a_x/y/z, vertex_b_x/y/z, vertex_c_x/y/z, each signed Q7.8.
// Master channel: o_m_tdata carries normal_x, normal_y, normal_z (signed Q1.14,
// lowest bit up) and o_m_tuser carries the degenerate flag.
// An accepted transfer passes through 32 square-root stages, 15 divider stages,
// and eight more for edges, cross product, magnitude, scaling, squares, sum
// and output before its result shows on the master side.
// One triangle is taken every cycle when not stalled; every stage is registered.
// A zero cross product gives (0,1,0) with the degenerate flag set.
// The whole pipeline advances on one enable: while a result waits on the
// master side and i_m_tready is low, every stage holds and o_s_tready drops;
// nothing is lost or repeated.
// Synchronous active-low reset clears all valid bits; data registers are not
// reset. The first transfer may be taken in the cycle after reset is released.
module triangle_face_normal_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (lowest bit up)
    input  logic [143:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // normal_x, normal_y, normal_z (lowest bit up)
    output logic [47:0]  o_m_tdata,
    // degenerate
    output logic         o_m_tuser
);
    import tfn_pkg::*;

    localparam int NST = 6 + (SQRT_STEPS + 1) + QUOT_W + 1;

    logic en;
    logic [NST-1:0] r_vld;

    assign en = !r_vld[NST-1] || i_m_tready;
    assign o_s_tready = en;
    assign o_m_tvalid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], i_s_tvalid};
        end
    end

    // edge vectors
    logic signed [EDGE_W-1:0] r_u [3];
    logic signed [EDGE_W-1:0] r_v [3];
    logic signed [COORD_W-1:0] crd [9];

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            crd[k] = signed'(i_s_tdata[k*COORD_W +: COORD_W]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_u[k] <= EDGE_W'(crd[3+k]) - EDGE_W'(crd[k]);
                r_v[k] <= EDGE_W'(crd[6+k]) - EDGE_W'(crd[k]);
            end
        end
    end

    // partial products of the cross product
    logic signed [PROD_W-1:0] r_p [6];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p[0] <= r_u[1] * r_v[2];
            r_p[1] <= r_u[2] * r_v[1];
            r_p[2] <= r_u[2] * r_v[0];
            r_p[3] <= r_u[0] * r_v[2];
            r_p[4] <= r_u[0] * r_v[1];
            r_p[5] <= r_u[1] * r_v[0];
        end
    end

    logic signed [CROSS_W-1:0] r_n [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_n[k] <= CROSS_W'(r_p[2*k]) - CROSS_W'(r_p[2*k+1]);
            end
        end
    end

    // magnitudes and signs
    logic [MAG_W-1:0] r_mg [3];
    t_meta            r_mg_meta;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_mg[k] <= r_n[k][CROSS_W-1] ? MAG_W'(-r_n[k]) : MAG_W'(r_n[k]);
                r_mg_meta.neg[k] <= r_n[k][CROSS_W-1];
            end
            r_mg_meta.degen <= (r_n[0] == '0) && (r_n[1] == '0) && (r_n[2] == '0);
        end
    end

    // reduce to 31 bits with a shared shift
    logic [MAG_W-1:0] mg_or;
    logic [1:0]       sh_amt;
    logic [RED_W-1:0] r_sh [3];
    t_meta            r_sh_meta;

    always_comb begin
        mg_or = r_mg[0] | r_mg[1] | r_mg[2];
        if (mg_or[33]) begin
            sh_amt = 2'd3;
        end else if (mg_or[32]) begin
            sh_amt = 2'd2;
        end else if (mg_or[31]) begin
            sh_amt = 2'd1;
        end else begin
            sh_amt = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_sh[k] <= RED_W'(r_mg[k] >> sh_amt);
            end
            r_sh_meta <= r_mg_meta;
        end
    end

    // squares
    logic [2*RED_W-1:0] r_sqr [3];
    logic [RED_W-1:0]   r_sqr_m [3];
    t_meta              r_sqr_meta;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_sqr[k] <= r_sh[k] * r_sh[k];
            end
            r_sqr_m    <= r_sh;
            r_sqr_meta <= r_sh_meta;
        end
    end

    // square-root pipeline, one result bit per stage; index 0 holds the sum
    logic [SUM_W-1:0] r_sq_rem [SQRT_STEPS+1];
    logic [SUM_W-1:0] r_sq_res [SQRT_STEPS+1];
    logic [RED_W-1:0] r_sq_m   [SQRT_STEPS+1][3];
    t_meta            r_sq_meta [SQRT_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_rem[0]  <= SUM_W'(r_sqr[0]) + SUM_W'(r_sqr[1]) + SUM_W'(r_sqr[2]);
            r_sq_res[0]  <= '0;
            r_sq_m[0]    <= r_sqr_m;
            r_sq_meta[0] <= r_sqr_meta;
        end
    end

    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
        localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (2 * (SQRT_STEPS - 1 - j));
        logic [SUM_W-1:0] trial;
        logic             ge;

        assign trial = r_sq_res[j] + BIT;
        assign ge    = r_sq_rem[j] >= trial;

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_rem[j+1]  <= ge ? r_sq_rem[j] - trial : r_sq_rem[j];
                r_sq_res[j+1]  <= ge ? (r_sq_res[j] >> 1) + BIT : r_sq_res[j] >> 1;
                r_sq_m[j+1]    <= r_sq_m[j];
                r_sq_meta[j+1] <= r_sq_meta[j];
            end
        end
    end

    // restoring divider: q = floor(m * 2^14 / L), one quotient bit per stage
    logic [ROOT_W-1:0] len;
    logic [ROOT_W-1:0] r_dv_r [QUOT_W][3];
    logic [QUOT_W-1:0] r_dv_q [QUOT_W][3];
    logic [ROOT_W-1:0] r_dv_l [QUOT_W];
    t_meta             r_dv_meta [QUOT_W];

    assign len = r_sq_res[SQRT_STEPS][ROOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                if (ROOT_W'(r_sq_m[SQRT_STEPS][k]) >= len) begin
                    r_dv_r[0][k] <= ROOT_W'(r_sq_m[SQRT_STEPS][k]) - len;
                    r_dv_q[0][k] <= QUOT_W'(1);
                end else begin
                    r_dv_r[0][k] <= ROOT_W'(r_sq_m[SQRT_STEPS][k]);
                    r_dv_q[0][k] <= '0;
                end
            end
            r_dv_l[0]    <= len;
            r_dv_meta[0] <= r_sq_meta[SQRT_STEPS];
        end
    end

    for (genvar d = 1; d < QUOT_W; d++) begin : g_div
        logic [ROOT_W:0] r2 [3];
        logic            ge [3];

        always_comb begin
            for (int k = 0; k < 3; k++) begin
                r2[k] = {r_dv_r[d-1][k], 1'b0};
                ge[k] = r2[k] >= {1'b0, r_dv_l[d-1]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int k = 0; k < 3; k++) begin
                    r_dv_r[d][k] <= ge[k] ? ROOT_W'(r2[k] - {1'b0, r_dv_l[d-1]})
                                          : ROOT_W'(r2[k]);
                    r_dv_q[d][k] <= {r_dv_q[d-1][k][QUOT_W-2:0], ge[k]};
                end
                r_dv_l[d]    <= r_dv_l[d-1];
                r_dv_meta[d] <= r_dv_meta[d-1];
            end
        end
    end

    // output register: apply sign, clamp and the degenerate fallback
    logic [OUT_W-1:0] r_out [3];
    logic             r_degen;
    logic [OUT_W-1:0] qc [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            qc[k] = (OUT_W'(r_dv_q[QUOT_W-1][k]) > ONE_OUT) ? ONE_OUT
                                                           : OUT_W'(r_dv_q[QUOT_W-1][k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_dv_meta[QUOT_W-1].degen) begin
                r_out[0] <= '0;
                r_out[1] <= ONE_OUT;
                r_out[2] <= '0;
            end else begin
                for (int k = 0; k < 3; k++) begin
                    r_out[k] <= r_dv_meta[QUOT_W-1].neg[k] ? -qc[k] : qc[k];
                end
            end
            r_degen <= r_dv_meta[QUOT_W-1].degen;
        end
    end

    assign o_m_tdata = {r_out[2], r_out[1], r_out[0]};
    assign o_m_tuser = r_degen;

`ifndef NO_ASSERTIONS
    a_degen_fallback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata == {16'd0, ONE_OUT, 16'd0}))
        else $error("degenerate result is not the fallback normal");

    a_stall_holds_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(r_vld)))
        else $error("pipeline moved while the master side stalled");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r_vld[0])
        else $error("accepted transfer did not enter the pipeline");
`endif

endmodule

// ===== verif/tfn_checker.sv =====
module tfn_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [143:0] i_s_tdata,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [47:0]  i_m_tdata,
    input  logic         i_m_tuser,
    output int           o_fail_count,
    output int           o_pending,
    output int           o_normals_seen,
    output int           o_degen_seen
);
    import tfn_pkg::*;

    localparam int DUE_DEPTH = 256;

    typedef struct {
        logic [OUT_W-1:0] nx;
        logic [OUT_W-1:0] ny;
        logic [OUT_W-1:0] nz;
        logic             degen;
    } t_normal;

    // ring of expected normals, written on input transfers, read on output
    t_normal normals_due [DUE_DEPTH];
    int      due_wr;
    int      due_rd;

    function automatic longint unsigned root64(longint unsigned s);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > s) bitv >>= 2;
        while (bitv != 0) begin
            if (s >= res + bitv) begin
                s   = s - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic t_normal face_normal(logic [143:0] tri_word);
        longint c[9];
        longint n[3];
        longint unsigned m[3];
        longint unsigned maxm;
        longint unsigned sum;
        longint unsigned len;
        longint unsigned q;
        logic [OUT_W-1:0] o[3];
        int shift;
        t_normal r;
        for (int i = 0; i < 9; i++) c[i] = longint'($signed(tri_word[16*i +: 16]));
        n[0] = (c[4]-c[1])*(c[8]-c[2]) - (c[5]-c[2])*(c[7]-c[1]);
        n[1] = (c[5]-c[2])*(c[6]-c[0]) - (c[3]-c[0])*(c[8]-c[2]);
        n[2] = (c[3]-c[0])*(c[7]-c[1]) - (c[4]-c[1])*(c[6]-c[0]);
        if (n[0] == 0 && n[1] == 0 && n[2] == 0) begin
            r.nx = '0; r.ny = ONE_OUT; r.nz = '0; r.degen = 1'b1;
            return r;
        end
        maxm = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = (n[i] < 0) ? longint'(-n[i]) : longint'(n[i]);
            if (m[i] > maxm) maxm = m[i];
        end
        shift = 0;
        while ((maxm >> shift) >= 64'h8000_0000) shift++;
        for (int i = 0; i < 3; i++) m[i] >>= shift;
        sum = m[0]*m[0] + m[1]*m[1] + m[2]*m[2];
        len = root64(sum);
        if (len == 0) len = 1;
        for (int i = 0; i < 3; i++) begin
            q = (m[i] << FRAC_OUT) / len;
            if (q > ONE_OUT) q = ONE_OUT;
            o[i] = (n[i] < 0) ? OUT_W'(-q) : OUT_W'(q);
        end
        r.nx = o[0]; r.ny = o[1]; r.nz = o[2]; r.degen = 1'b0;
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        t_normal want;
        if (!i_rst_n) begin
            o_fail_count   <= 0;
            o_normals_seen <= 0;
            o_degen_seen   <= 0;
            due_wr         <= 0;
            due_rd         <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                normals_due[due_wr % DUE_DEPTH] <= face_normal(i_s_tdata);
                due_wr <= due_wr + 1;
            end
            if (i_m_tvalid && i_m_tready) begin
                o_normals_seen <= o_normals_seen + 1;
                if (i_m_tuser) o_degen_seen <= o_degen_seen + 1;
                if (due_wr == due_rd) begin
                    $error("normal with nothing expected: %h", i_m_tdata);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = normals_due[due_rd % DUE_DEPTH];
                    due_rd <= due_rd + 1;
                    if (i_m_tdata[15:0] !== want.nx || i_m_tdata[31:16] !== want.ny ||
                        i_m_tdata[47:32] !== want.nz || i_m_tuser !== want.degen)
                        o_fail_count <= o_fail_count + 1;
                    if (i_m_tdata[15:0] !== want.nx)
                        $error("normal_x expected %h got %h", want.nx, i_m_tdata[15:0]);
                    if (i_m_tdata[31:16] !== want.ny)
                        $error("normal_y expected %h got %h", want.ny, i_m_tdata[31:16]);
                    if (i_m_tdata[47:32] !== want.nz)
                        $error("normal_z expected %h got %h", want.nz, i_m_tdata[47:32]);
                    if (i_m_tuser !== want.degen)
                        $error("degenerate expected %b got %b", want.degen, i_m_tuser);
                end
            end
        end
    end

    assign o_pending = due_wr - due_rd;
endmodule

// ===== verif/tb_triangle_face_normal_core.sv =====
module tb_triangle_face_normal_core;
    localparam int WATCHDOG = 5000;
    localparam int DRAIN    = 80;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [143:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [47:0]  m_tdata;
    logic         m_tuser;
    int           fail_count;
    int           pending;
    int           normals_seen;
    int           degen_seen;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           idle_cycles;

    triangle_face_normal_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready), .i_s_tdata(s_tdata),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .o_m_tdata(m_tdata), .o_m_tuser(m_tuser)
    );

    tfn_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .i_m_tuser(m_tuser),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_normals_seen(normals_seen), .o_degen_seen(degen_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // watchdog: count cycles with no transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("watchdog expired");
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(negedge i_clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    function automatic logic [15:0] rand_coord(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(15)) - 16'd8;
            2: return $urandom_range(1) ? 16'h7fff : 16'h8000;
            default: return 16'($urandom_range(511)) - 16'd256;
        endcase
    endfunction

    function automatic logic [143:0] rand_triangle();
        logic [143:0] t;
        int mode;
        mode = $urandom_range(3);
        for (int i = 0; i < 9; i++) t[16*i +: 16] = rand_coord(mode);
        case ($urandom_range(7))
            0: t[143:96] = t[47:0];              // c equals a
            1: t[95:48]  = t[47:0];              // b equals a
            2: t[143:96] = t[95:48];             // b equals c
            3: for (int i = 0; i < 3; i++)       // c on the line a-b
                   t[96+16*i +: 16] = 16'(2 * t[48+16*i +: 16] - t[16*i +: 16]);
            default: ;
        endcase
        return t;
    endfunction

    // hold the transfer until accepted; a later idle wait or drain drops valid
    task automatic send_triangle(logic [143:0] t);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= t;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain_all();
        s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        logic [143:0] t;
        i_rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, degenerate shapes, axis-aligned faces
        send_triangle('0);
        send_triangle({9{16'h7fff}});
        send_triangle({9{16'h8000}});
        send_triangle({16'h0000, 16'h0100, 16'h0000, 16'h0000, 16'h0000,
                       16'h0100, 16'h0000, 16'h0000, 16'h0000});
        send_triangle({16'h0000, 16'h0000, 16'h0100, 16'h0100, 16'h0000,
                       16'h0000, 16'h0000, 16'h0000, 16'h0000});
        send_triangle({16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h0100,
                       16'h0000, 16'h0000, 16'h0000, 16'h0000});
        send_triangle({16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                       16'h7fff, 16'h8000, 16'h8000, 16'h8000});
        send_triangle({16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                       16'h8000, 16'h7fff, 16'h7fff, 16'h7fff});
        send_triangle({16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0001,
                       16'h0000, 16'h0000, 16'h0000, 16'h0000});
        send_triangle({16'h8000, 16'h7fff, 16'h0000, 16'h7fff, 16'h0000,
                       16'h8000, 16'h0000, 16'h8000, 16'h7fff});
        send_triangle({16'h0003, 16'h0003, 16'h0003, 16'h0002, 16'h0002,
                       16'h0002, 16'h0001, 16'h0001, 16'h0001});
        for (int i = 0; i < 8; i++) begin
            t = rand_triangle();
            t[16*i +: 16] = 16'hffff;
            send_triangle(t);
        end
        // hold off until every directed normal is back
        drain_all();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                3: begin send_idle_pct = 18; recv_stall_pct = 18; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (int k = 0; k < 100; k++) send_triangle(rand_triangle());
        end

        recv_stall_pct = 0;
        drain_all();
        repeat (DRAIN) @(negedge i_clk);
        $display("covered %0d triangles, %0d degenerate, across idle and stall phases",
                 normals_seen, degen_seen);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
